// ----- rtl/stb_pkg.sv -----
// Shared types, register map and constants for the silence trim bounds block.
`default_nettype none

package stb_pkg;

  // Default widths of the frame counter and of one sample
  localparam int DEF_FRAME_BITS  = 24;
  localparam int DEF_SAMPLE_BITS = 24;

  // Configuration register widths
  localparam int THR_BITS  = 23;
  localparam int MODE_BITS = 2;
  localparam int CHAN_BITS = 4;
  localparam int PAD_BITS  = 4;

  // APB address and data
  localparam int ADDR_BITS = 4;
  localparam int DATA_BITS = 32;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_MODE      = 2'd1;
  localparam logic [1:0] REG_CHANNELS  = 2'd2;
  localparam logic [1:0] REG_PAD       = 2'd3;

  // Reset values
  localparam logic [THR_BITS-1:0]  THRESHOLD_RESET = 23'd265;
  localparam logic [MODE_BITS-1:0] MODE_RESET      = 2'd2;
  localparam logic [CHAN_BITS-1:0] CHANNELS_RESET  = 4'd1;
  localparam logic [PAD_BITS-1:0]  PAD_RESET       = 4'd4;

  // Region mode codes; the unused codes act as both
  localparam logic [MODE_BITS-1:0] MODE_START_ONLY = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_END_ONLY   = 2'd1;

  // Largest channel count per frame
  localparam logic [CHAN_BITS-1:0] CHAN_MAX = 4'd8;

  typedef enum logic [1:0] {
    TRIM_NEEDED   = 2'd0,
    TRIM_NONE     = 2'd1,
    TRIM_OVERFLOW = 2'd2
  } trim_status_t;

  typedef struct packed {
    logic [THR_BITS-1:0]  quiet_level;
    logic [MODE_BITS-1:0] region_mode;
    logic [CHAN_BITS-1:0] channel_count;
    logic [PAD_BITS-1:0]  pad_frames;
  } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/stb_sample_if.sv -----
// Sample channel: one interleaved audio sample per request.
`default_nettype none

interface stb_sample_if #(
  parameter int SAMPLE_BITS = stb_pkg::DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_value;
  logic                          clip_last;

  modport source (output valid, output sample_value, output clip_last, input ready);
  modport sink   (input valid, input sample_value, input clip_last, output ready);
endinterface

`default_nettype wire

// ----- rtl/stb_result_if.sv -----
// Result channel: trim bounds of one clip per request.
`default_nettype none

interface stb_result_if #(
  parameter int FRAME_BITS = stb_pkg::DEF_FRAME_BITS
);
  logic                  valid;
  logic                  ready;
  logic [FRAME_BITS-1:0] keep_start;
  logic [FRAME_BITS-1:0] keep_end;
  logic [FRAME_BITS-1:0] total_frames;
  logic [1:0]            trim_status;

  modport source (output valid, output keep_start, output keep_end, output total_frames,
                  output trim_status, input ready);
  modport sink   (input valid, input keep_start, input keep_end, input total_frames,
                  input trim_status, output ready);
endinterface

`default_nettype wire

// ----- rtl/stb_regs.sv -----
// APB configuration registers.
`default_nettype none

module stb_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [stb_pkg::ADDR_BITS-1:0]  paddr,
  input  wire logic [stb_pkg::DATA_BITS-1:0]  pwdata,
  output logic      [stb_pkg::DATA_BITS-1:0]  prdata,
  output logic                                pready,
  output stb_pkg::cfg_t                       cfg
);

  stb_pkg::cfg_t cfg_reg;
  logic          wr_en;
  logic [1:0]    reg_index;

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite;
  assign reg_index = paddr[3:2];
  assign cfg       = cfg_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg.quiet_level   <= stb_pkg::THRESHOLD_RESET;
      cfg_reg.region_mode   <= stb_pkg::MODE_RESET;
      cfg_reg.channel_count <= stb_pkg::CHANNELS_RESET;
      cfg_reg.pad_frames    <= stb_pkg::PAD_RESET;
    end else if (wr_en) begin
      unique case (reg_index)
        stb_pkg::REG_THRESHOLD: cfg_reg.quiet_level   <= pwdata[stb_pkg::THR_BITS-1:0];
        stb_pkg::REG_MODE:      cfg_reg.region_mode   <= pwdata[stb_pkg::MODE_BITS-1:0];
        stb_pkg::REG_CHANNELS:  cfg_reg.channel_count <= pwdata[stb_pkg::CHAN_BITS-1:0];
        stb_pkg::REG_PAD:       cfg_reg.pad_frames    <= pwdata[stb_pkg::PAD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_index)
      stb_pkg::REG_THRESHOLD: prdata[stb_pkg::THR_BITS-1:0]  = cfg_reg.quiet_level;
      stb_pkg::REG_MODE:      prdata[stb_pkg::MODE_BITS-1:0] = cfg_reg.region_mode;
      stb_pkg::REG_CHANNELS:  prdata[stb_pkg::CHAN_BITS-1:0] = cfg_reg.channel_count;
      stb_pkg::REG_PAD:       prdata[stb_pkg::PAD_BITS-1:0]  = cfg_reg.pad_frames;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/stb_tracker.sv -----
// Input register, loud detection and per-clip frame tracking; emits one clip record.
`default_nettype none

module stb_tracker #(
  parameter int FRAME_BITS  = stb_pkg::DEF_FRAME_BITS,
  parameter int SAMPLE_BITS = stb_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire stb_pkg::cfg_t         cfg,
  stb_sample_if.sink                 samples,
  output logic                       rec_valid,
  input  wire logic                  rec_ready,
  output logic [FRAME_BITS-1:0]      rec_total,
  output logic [FRAME_BITS-1:0]      rec_first,
  output logic [FRAME_BITS-1:0]      rec_last,
  output logic                       rec_any,
  output logic                       rec_ovf
);

  localparam int CW = ((SAMPLE_BITS > stb_pkg::THR_BITS) ? SAMPLE_BITS
                                                         : stb_pkg::THR_BITS) + 1;
  localparam logic [FRAME_BITS-1:0] FRAME_MAX = '1;

  // Input stage
  logic s1_valid;
  logic s1_loud;
  logic s1_last;

  // Clip state
  logic [FRAME_BITS-1:0] frame_counter;
  logic [2:0]            channel_counter;
  logic                  frame_is_loud;
  logic                  any_loud_seen;
  logic [FRAME_BITS-1:0] first_loud_frame;
  logic [FRAME_BITS-1:0] last_loud_frame;
  logic                  count_overflow;

  logic                   in_take;
  logic                   s1_take;
  logic                   rec_free;
  logic                   sample_neg;
  logic [SAMPLE_BITS-1:0] mag_bits;
  logic [CW-1:0]          mag_ext;
  logic [CW-1:0]          thr_ext;
  logic                   loud_in;
  logic [2:0]             chans_m1;
  logic                   loud_now;
  logic                   frame_done;
  logic                   frame_at_max;
  logic [FRAME_BITS-1:0]  first_next;
  logic [FRAME_BITS-1:0]  frame_inc;

  assign rec_free      = !rec_valid || rec_ready;
  assign s1_take       = s1_valid && (!s1_last || rec_free);
  assign samples.ready = !s1_valid || s1_take;
  assign in_take       = samples.valid && samples.ready;

  // |x| > thr; for negative x, -x = ~x + 1, so the test becomes ~x >= thr
  assign sample_neg = samples.sample_value[SAMPLE_BITS-1];
  assign mag_bits   = sample_neg ? ~samples.sample_value : samples.sample_value;
  assign mag_ext    = {{(CW-SAMPLE_BITS){1'b0}}, mag_bits};
  assign thr_ext    = {{(CW-stb_pkg::THR_BITS){1'b0}}, cfg.quiet_level};
  assign loud_in    = sample_neg ? (mag_ext >= thr_ext) : (mag_ext > thr_ext);

  always_comb begin
    if (cfg.channel_count == '0) begin
      chans_m1 = 3'd0;
    end else if (cfg.channel_count >= stb_pkg::CHAN_MAX) begin
      chans_m1 = 3'd7;
    end else begin
      chans_m1 = cfg.channel_count[2:0] - 3'd1;
    end
  end

  assign loud_now     = frame_is_loud || s1_loud;
  assign frame_done   = s1_last || (channel_counter >= chans_m1);
  assign frame_at_max = (frame_counter == FRAME_MAX);
  assign first_next   = (loud_now && !any_loud_seen) ? frame_counter : first_loud_frame;
  assign frame_inc    = frame_counter + FRAME_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (samples.ready) begin
      s1_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_loud <= loud_in;
      s1_last <= samples.clip_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_counter    <= '0;
      channel_counter  <= '0;
      frame_is_loud    <= 1'b0;
      any_loud_seen    <= 1'b0;
      first_loud_frame <= '0;
      last_loud_frame  <= '0;
      count_overflow   <= 1'b0;
    end else if (s1_take) begin
      if (s1_last) begin
        // clip closes: start over for the next one
        frame_counter    <= '0;
        channel_counter  <= '0;
        frame_is_loud    <= 1'b0;
        any_loud_seen    <= 1'b0;
        first_loud_frame <= '0;
        last_loud_frame  <= '0;
        count_overflow   <= 1'b0;
      end else if (frame_done) begin
        if (loud_now) begin
          first_loud_frame <= first_next;
          last_loud_frame  <= frame_counter;
          any_loud_seen    <= 1'b1;
        end
        if (frame_at_max) begin
          count_overflow <= 1'b1;
        end else begin
          frame_counter <= frame_inc;
        end
        channel_counter <= '0;
        frame_is_loud   <= 1'b0;
      end else begin
        channel_counter <= channel_counter + 3'd1;
        frame_is_loud   <= loud_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (rec_free) begin
      rec_valid <= s1_take && s1_last;
    end
  end

  // The last sample always closes its frame
  always_ff @(posedge clk) begin
    if (s1_take && s1_last) begin
      rec_total <= frame_at_max ? frame_counter : frame_inc;
      rec_first <= loud_now ? first_next : first_loud_frame;
      rec_last  <= loud_now ? frame_counter : last_loud_frame;
      rec_any   <= any_loud_seen || loud_now;
      rec_ovf   <= count_overflow || frame_at_max;
    end
  end

`ifndef ASSERT_OFF
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    s1_take && s1_last |=> frame_counter == '0 && channel_counter == '0 && !any_loud_seen)
    else $error("clip state not cleared after last sample");

  a_rec_hold: assert property (@(posedge clk) disable iff (rst)
    rec_valid && !rec_ready |=> rec_valid && $stable(rec_total) && $stable(rec_first))
    else $error("clip record changed while stalled");

  a_ovf_sat: assert property (@(posedge clk) disable iff (rst)
    count_overflow |-> frame_counter == FRAME_MAX)
    else $error("overflow flag set below saturation");
`endif

endmodule

`default_nettype wire

// ----- rtl/stb_bounds.sv -----
// Pads and clamps the kept frame bounds of one clip and holds the result.
`default_nettype none

module stb_bounds #(
  parameter int FRAME_BITS = stb_pkg::DEF_FRAME_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire stb_pkg::cfg_t         cfg,
  input  wire logic                  rec_valid,
  output logic                       rec_ready,
  input  wire logic [FRAME_BITS-1:0] rec_total,
  input  wire logic [FRAME_BITS-1:0] rec_first,
  input  wire logic [FRAME_BITS-1:0] rec_last,
  input  wire logic                  rec_any,
  input  wire logic                  rec_ovf,
  stb_result_if.source               results
);

  localparam int EW = FRAME_BITS + 2;
  localparam logic [FRAME_BITS-1:0] FRAME_MAX = '1;

  logic [FRAME_BITS-1:0]  pad_f;
  logic [EW-1:0]          pad_e;
  logic [EW-1:0]          total_e;
  logic [FRAME_BITS-1:0]  start_base;
  logic [FRAME_BITS-1:0]  start_val;
  logic [EW-1:0]          end_base;
  logic [EW-1:0]          end_sum;
  logic [FRAME_BITS-1:0]  end_val;
  stb_pkg::trim_status_t  status_val;

  logic                  out_valid;
  logic [FRAME_BITS-1:0] out_start;
  logic [FRAME_BITS-1:0] out_end;
  logic [FRAME_BITS-1:0] out_total;
  stb_pkg::trim_status_t out_status;

  assign rec_ready = !out_valid || results.ready;

  assign pad_f   = {{(FRAME_BITS-stb_pkg::PAD_BITS){1'b0}}, cfg.pad_frames};
  assign pad_e   = {{(EW-stb_pkg::PAD_BITS){1'b0}}, cfg.pad_frames};
  assign total_e = {2'b00, rec_total};

  always_comb begin
    start_base = (rec_any && cfg.region_mode != stb_pkg::MODE_END_ONLY) ? rec_first : '0;
    end_base   = (rec_any && cfg.region_mode != stb_pkg::MODE_START_ONLY)
               ? ({2'b00, rec_last} + EW'(1)) : total_e;
    start_val  = (start_base < pad_f) ? '0 : (start_base - pad_f);
    end_sum    = end_base + pad_e;
    end_val    = (end_sum > total_e) ? rec_total : end_sum[FRAME_BITS-1:0];
    priority if (rec_ovf) begin
      status_val = stb_pkg::TRIM_OVERFLOW;
    end else if (start_val == '0 && end_val == rec_total) begin
      status_val = stb_pkg::TRIM_NONE;
    end else begin
      status_val = stb_pkg::TRIM_NEEDED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rec_ready) begin
      out_valid <= rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_valid && rec_ready) begin
      out_start  <= start_val;
      out_end    <= end_val;
      out_total  <= rec_total;
      out_status <= status_val;
    end
  end

  assign results.valid        = out_valid;
  assign results.keep_start   = out_start;
  assign results.keep_end     = out_end;
  assign results.total_frames = out_total;
  assign results.trim_status  = out_status;

`ifndef ASSERT_OFF
  a_bounds_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_start <= out_end && out_end <= out_total)
    else $error("kept bounds out of order");

  a_ovf_total: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == stb_pkg::TRIM_OVERFLOW |-> out_total == FRAME_MAX)
    else $error("overflow status with unsaturated total");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !results.ready |=> out_valid && $stable(out_end))
    else $error("result dropped while stalled");
`endif

endmodule

`default_nettype wire

// ----- rtl/silence_trim_bounds.sv -----
// Top level: finds the kept frame bounds of an audio clip from its loud frames.
//
//   channel   dir   request moves                 fields
//   samples   in    one interleaved sample        sample_value, clip_last
//   results   out   one result per clip           keep_start, keep_end, total_frames,
//                                                 trim_status
//   apb       in    one register write or read    threshold, mode, channels, pad
//
// One sample is accepted every cycle while intake is not stopped. A clip's result
// passes through the input register, the frame tracker and the bounds register.
// rst is synchronous, active high; it clears clip state and loads register defaults.
// A stalled result holds; intake stops only when a clip's last sample finds two
// finished clips waiting.
`default_nettype none

module silence_trim_bounds #(
  parameter int FRAME_BITS  = stb_pkg::DEF_FRAME_BITS,
  parameter int SAMPLE_BITS = stb_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [stb_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [stb_pkg::DATA_BITS-1:0] pwdata,
  output logic      [stb_pkg::DATA_BITS-1:0] prdata,
  output logic                               pready,
  stb_sample_if.sink                         samples,
  stb_result_if.source                       results
);

  stb_pkg::cfg_t         cfg;
  logic                  rec_valid;
  logic                  rec_ready;
  logic [FRAME_BITS-1:0] rec_total;
  logic [FRAME_BITS-1:0] rec_first;
  logic [FRAME_BITS-1:0] rec_last;
  logic                  rec_any;
  logic                  rec_ovf;

  stb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  stb_tracker #(
    .FRAME_BITS  (FRAME_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_tracker (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .samples   (samples),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec_total (rec_total),
    .rec_first (rec_first),
    .rec_last  (rec_last),
    .rec_any   (rec_any),
    .rec_ovf   (rec_ovf)
  );

  stb_bounds #(
    .FRAME_BITS (FRAME_BITS)
  ) u_bounds (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec_total (rec_total),
    .rec_first (rec_first),
    .rec_last  (rec_last),
    .rec_any   (rec_any),
    .rec_ovf   (rec_ovf),
    .results   (results)
  );

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the silence trim bounds block.
`default_nettype none

module tb;
  import stb_pkg::*;

  localparam int LIMIT_CYCLES = 500000;
  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_REPORTS = 10;
  localparam logic [23:0] SAMPLE_MAX = 24'h7FFFFF;
  localparam logic [23:0] SAMPLE_MIN = 24'h800000;

  typedef struct packed {
    logic [23:0]  keep_start;
    logic [23:0]  keep_end;
    logic [23:0]  total_frames;
    trim_status_t trim_status;
  } trim_bounds_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0] pwdata;
  logic [DATA_BITS-1:0] prdata;
  logic pready;

  stb_sample_if samp_ch ();
  stb_result_if res_ch ();

  silence_trim_bounds i_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .samples (samp_ch),
    .results (res_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Register copy and clip state of the bounds predictor
  cfg_t        shadow_cfg;
  logic [23:0] frames_done;
  int          chan_pos;
  bit          frame_loud;
  bit          seen_loud;
  logic [23:0] first_loud;
  logic [23:0] last_loud;
  bit          frame_ovf;

  trim_bounds_t pending_bounds[$];

  int  mismatch_count = 0;
  int  samples_sent = 0;
  int  clips_sent = 0;
  int  settings_used = 0;
  int  cycle_count = 0;
  bit  tx_idle_on = 1'b0;
  bit  rx_stall_on = 1'b0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void clear_clip_state();
    frames_done = '0;
    chan_pos = 0;
    frame_loud = 1'b0;
    seen_loud = 1'b0;
    first_loud = '0;
    last_loud = '0;
    frame_ovf = 1'b0;
  endfunction

  // Advance the clip state by one sample; returns 1 with the bounds on the clip's end
  function automatic bit track_sample(input logic [23:0] s, input bit clip_end,
                                      output trim_bounds_t b);
    logic [23:0] mag;
    int chans;
    int lo;
    int hi;
    int total;
    int pad;
    chans = shadow_cfg.channel_count;
    if (chans == 0) chans = 1;
    if (chans > CHAN_MAX) chans = CHAN_MAX;
    mag = s[23] ? (~s + 24'd1) : s;
    if (mag > {1'b0, shadow_cfg.quiet_level}) frame_loud = 1'b1;
    b = '0;
    if (clip_end || chan_pos + 1 >= chans) begin
      if (frame_loud) begin
        if (!seen_loud) first_loud = frames_done;
        last_loud = frames_done;
        seen_loud = 1'b1;
      end
      if (frames_done == '1) frame_ovf = 1'b1;
      else frames_done = frames_done + 24'd1;
      chan_pos = 0;
      frame_loud = 1'b0;
    end else begin
      chan_pos = chan_pos + 1;
    end
    if (!clip_end) return 1'b0;
    total = int'(frames_done);
    pad = int'(shadow_cfg.pad_frames);
    lo = 0;
    hi = total;
    if (seen_loud && shadow_cfg.region_mode != MODE_END_ONLY) lo = int'(first_loud);
    if (seen_loud && shadow_cfg.region_mode != MODE_START_ONLY) hi = int'(last_loud) + 1;
    lo = (lo < pad) ? 0 : lo - pad;
    hi = hi + pad;
    if (hi > total) hi = total;
    b.keep_start = lo[23:0];
    b.keep_end = hi[23:0];
    b.total_frames = frames_done;
    if (frame_ovf) b.trim_status = TRIM_OVERFLOW;
    else if (lo == 0 && hi == total) b.trim_status = TRIM_NONE;
    else b.trim_status = TRIM_NEEDED;
    clear_clip_state();
    return 1'b1;
  endfunction

  function automatic logic [31:0] reg_value(input logic [1:0] idx);
    case (idx)
      REG_THRESHOLD: return 32'(shadow_cfg.quiet_level);
      REG_MODE:      return 32'(shadow_cfg.region_mode);
      REG_CHANNELS:  return 32'(shadow_cfg.channel_count);
      default:       return 32'(shadow_cfg.pad_frames);
    endcase
  endfunction

  function automatic logic [31:0] reg_mask(input logic [1:0] idx);
    case (idx)
      REG_THRESHOLD: return (32'd1 << THR_BITS) - 32'd1;
      REG_MODE:      return (32'd1 << MODE_BITS) - 32'd1;
      REG_CHANNELS:  return (32'd1 << CHAN_BITS) - 32'd1;
      default:       return (32'd1 << PAD_BITS) - 32'd1;
    endcase
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("mismatch: %s", msg);
  endtask

  // Called right after a falling edge; returns right after a falling edge
  task automatic apb_xfer(input bit wr, input logic [1:0] idx, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = {idx, 2'b00};
    pwdata = wdata;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic check_reg(input logic [1:0] idx);
    logic [31:0] rd;
    apb_xfer(1'b0, idx, 32'd0, rd);
    if ((rd & reg_mask(idx)) !== reg_value(idx))
      note_mismatch($sformatf("register %0d read %0h, expected %0h", idx, rd, reg_value(idx)));
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] rd;
    apb_xfer(1'b1, idx, value, rd);
    case (idx)
      REG_THRESHOLD: shadow_cfg.quiet_level = value[THR_BITS-1:0];
      REG_MODE:      shadow_cfg.region_mode = value[MODE_BITS-1:0];
      REG_CHANNELS:  shadow_cfg.channel_count = value[CHAN_BITS-1:0];
      default:       shadow_cfg.pad_frames = value[PAD_BITS-1:0];
    endcase
    check_reg(idx);
  endtask

  // Drop valid, let every pending result drain, then hold off for the pipeline
  task automatic settle_idle();
    samp_ch.valid = 1'b0;
    while (pending_bounds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_sample(input logic signed [23:0] s, input bit clip_end);
    int gap;
    trim_bounds_t b;
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      samp_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    samp_ch.valid = 1'b1;
    samp_ch.sample_value = s;
    samp_ch.clip_last = clip_end;
    @(posedge clk);
    while (!samp_ch.ready) @(posedge clk);
    samples_sent++;
    if (track_sample(s, clip_end, b)) begin
      pending_bounds.push_back(b);
      clips_sent++;
    end
    @(negedge clk);
  endtask

  function automatic logic [23:0] quiet_sample();
    logic [23:0] mag;
    mag = 24'($urandom_range(0, int'(shadow_cfg.quiet_level)));
    return $urandom_range(0, 1) ? (~mag + 24'd1) : mag;
  endfunction

  function automatic logic [23:0] loud_sample();
    logic [23:0] mag;
    if (shadow_cfg.quiet_level == '1 || $urandom_range(0, 15) == 0) return SAMPLE_MIN;
    if ($urandom_range(0, 7) == 0) mag = 24'(shadow_cfg.quiet_level) + 24'd1;
    else mag = 24'($urandom_range(int'(shadow_cfg.quiet_level) + 1, int'(SAMPLE_MAX)));
    return $urandom_range(0, 1) ? (~mag + 24'd1) : mag;
  endfunction

  // One clip: silence, a loud region with silent holes, silence; some clips are noise or all silent
  task automatic send_clip();
    int chans;
    int frames;
    int kind;
    int a;
    int b;
    int cut;
    int lim;
    int k;
    int n;
    bit fl;
    chans = shadow_cfg.channel_count;
    if (chans == 0) chans = 1;
    if (chans > CHAN_MAX) chans = CHAN_MAX;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      n = $urandom_range(1, 30);
      for (int i = 0; i < n; i++)
        send_sample(24'($urandom), i == n - 1 || $urandom_range(0, 15) == 0);
      return;
    end
    frames = $urandom_range(1, 24);
    a = $urandom_range(0, frames - 1);
    b = $urandom_range(a, frames - 1);
    cut = (kind == 1) ? $urandom_range(1, chans) : chans;
    for (int f = 0; f < frames; f++) begin
      fl = kind != 2 && f >= a && f <= b && (f == a || f == b || $urandom_range(0, 2) != 0);
      k = $urandom_range(0, chans - 1);
      lim = (f == frames - 1) ? cut : chans;
      for (int c = 0; c < lim; c++)
        send_sample((fl && (c == k || $urandom_range(0, 3) == 0)) ? loud_sample()
                                                                    : quiet_sample(),
                    f == frames - 1 && c == lim - 1);
    end
  endtask

  task automatic test_register_defaults();
    check_reg(REG_THRESHOLD);
    check_reg(REG_MODE);
    check_reg(REG_CHANNELS);
    check_reg(REG_PAD);
    settings_used++;
  endtask

  task automatic test_directed_clips();
    // threshold edges at reset settings, padding clamped on both sides
    send_sample(24'sd0, 1'b0);
    send_sample(24'sd265, 1'b0);
    send_sample(-24'sd265, 1'b0);
    send_sample(24'sd266, 1'b0);
    send_sample(24'sd0, 1'b0);
    send_sample(24'sd0, 1'b0);
    send_sample(-24'sd266, 1'b0);
    send_sample(24'sd0, 1'b1);
    // single silent sample is a whole clip with nothing loud
    send_sample(24'sd0, 1'b1);
    settle_idle();

    // top threshold: only the most negative sample is loud; trim the end only
    cfg_write(REG_THRESHOLD, 32'(SAMPLE_MAX));
    cfg_write(REG_PAD, 32'd0);
    cfg_write(REG_MODE, 32'(MODE_END_ONLY));
    settings_used++;
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(24'sd0, 1'b1);
    settle_idle();

    // zero threshold, channel count zero acts as one, trim the start only
    cfg_write(REG_THRESHOLD, 32'd0);
    cfg_write(REG_MODE, 32'(MODE_START_ONLY));
    cfg_write(REG_CHANNELS, 32'd0);
    settings_used++;
    send_sample(24'sd0, 1'b0);
    send_sample(24'sd0, 1'b0);
    send_sample(24'sd1, 1'b1);
    settle_idle();

    // oversized channel count acts as eight, undefined mode trims both,
    // largest pad, partial final frame
    cfg_write(REG_CHANNELS, 32'd15);
    cfg_write(REG_MODE, 32'd3);
    cfg_write(REG_PAD, 32'd15);
    settings_used++;
    for (int i = 0; i < 8; i++) send_sample(24'sd0, 1'b0);
    send_sample(24'sd0, 1'b0);
    send_sample(-24'sd1, 1'b1);
    settle_idle();
  endtask

  task automatic test_random_clips();
    int base_samples;
    int phase_start;
    int r;
    base_samples = samples_sent;
    while (samples_sent - base_samples < 700) begin
      r = $urandom_range(0, 9);
      cfg_write(REG_THRESHOLD, (r == 0) ? 32'd0 :
                               (r == 1) ? 32'(SAMPLE_MAX) :
                               (r == 2) ? 32'd265 :
                               (r < 7)  ? 32'($urandom_range(0, 4000)) :
                                          32'($urandom_range(0, int'(SAMPLE_MAX))));
      cfg_write(REG_MODE, 32'($urandom_range(0, 3)));
      cfg_write(REG_CHANNELS, ($urandom_range(0, 9) < 6) ? 32'($urandom_range(1, 4))
                                                         : 32'($urandom_range(0, 15)));
      r = $urandom_range(0, 3);
      cfg_write(REG_PAD, (r == 0) ? 32'd0 : (r == 1) ? 32'd15 : 32'($urandom_range(0, 15)));
      tx_idle_on = (settings_used % 3) != 0;
      rx_stall_on = (settings_used % 4) != 1;
      settings_used++;
      phase_start = samples_sent;
      while (samples_sent - phase_start < 90) send_clip();
      settle_idle();
    end
  endtask

  // Result receiver: random stalls, short mostly, now and then long
  initial begin
    int hold;
    hold = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        res_ch.ready = 1'b0;
        hold--;
      end else begin
        res_ch.ready = 1'b1;
        if (rx_stall_on && $urandom_range(0, 3) == 0) hold = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    trim_bounds_t want;
    trim_bounds_t got;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.keep_start = res_ch.keep_start;
      got.keep_end = res_ch.keep_end;
      got.total_frames = res_ch.total_frames;
      got.trim_status = trim_status_t'(res_ch.trim_status);
      if (pending_bounds.size() == 0) begin
        note_mismatch($sformatf("result with no clip pending: start %0d end %0d total %0d",
                                got.keep_start, got.keep_end, got.total_frames));
      end else begin
        want = pending_bounds.pop_front();
        if (got !== want)
          note_mismatch($sformatf({"start %0d/%0d end %0d/%0d total %0d/%0d status %0d/%0d",
                                   " (expected/actual)"},
                                  want.keep_start, got.keep_start, want.keep_end, got.keep_end,
                                  want.total_frames, got.total_frames,
                                  want.trim_status, got.trim_status));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_bounds.size());
      $display("FAIL silence_trim_bounds");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    samp_ch.valid = 1'b0;
    samp_ch.sample_value = '0;
    samp_ch.clip_last = 1'b0;
    shadow_cfg.quiet_level = THRESHOLD_RESET;
    shadow_cfg.region_mode = MODE_RESET;
    shadow_cfg.channel_count = CHANNELS_RESET;
    shadow_cfg.pad_frames = PAD_RESET;
    clear_clip_state();
    repeat (6) @(negedge clk);
    rst = 1'b0;

    test_register_defaults();
    test_directed_clips();
    test_random_clips();

    samp_ch.valid = 1'b0;
    while (pending_bounds.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending_bounds.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", pending_bounds.size()));

    $display("run covered %0d samples in %0d clips over %0d register settings",
             samples_sent, clips_sent, settings_used);
    $display("threshold edges, channel counts, modes, pads and partial frames; %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS silence_trim_bounds");
    end else begin
      $display("FAIL silence_trim_bounds");
    end
    $finish;
  end

endmodule

`default_nettype wire
